[rtl/core/flash_page_record_wear_leveler_unit_macros.svh]
// Assertion helpers used by the checker file.
`ifndef FLASH_PAGE_RECORD_WEAR_LEVELER_UNIT_MACROS_SVH
`define FLASH_PAGE_RECORD_WEAR_LEVELER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPWL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("fpwl check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FPWL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("fpwl check failed");

`endif

[rtl/core/fpwl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fpwl_pkg;

  // Page geometry
  localparam int unsigned PAGE_WORDS = 512;
  localparam int unsigned PAGE_AW    = $clog2(PAGE_WORDS);
  localparam int unsigned PTR_W      = PAGE_AW + 1;            // holds PAGE_WORDS itself
  localparam int unsigned WORDS_W    = 10;                     // ceil(length/4)
  localparam int unsigned CALC_W     = ((PTR_W > WORDS_W) ? PTR_W : WORDS_W) + 2;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(PAGE_WORDS - 1);
  localparam logic [PTR_W-1:0] PTR_PAGE = PTR_W'(PAGE_WORDS);

  localparam logic [31:0] WORD_ERASED = 32'hFFFF_FFFF;
  localparam logic [31:0] WORD_ZERO   = 32'h0000_0000;

  // Opcodes
  localparam logic [1:0] OP_START_WRITE = 2'd0;
  localparam logic [1:0] OP_WRITE_DATA  = 2'd1;
  localparam logic [1:0] OP_READ_BYTE   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ERASED = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // Config registers
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_WORD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEAR_ENABLE = 2'd1;
  localparam logic [31:0] HEADER_WORD_RST = 32'h5555_5555;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [10:0] length;
    logic [7:0]  data_byte;
    logic [10:0] read_offset;
  } fpwl_in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [1:0] status;
  } fpwl_out_t;

  typedef struct packed {
    logic [31:0] header_word;
    logic        wear_level_enable;
  } fpwl_cfg_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } fpwl_sts_t;

  // Record length in words, rounded up
  function automatic logic [WORDS_W-1:0] fpwl_words(input logic [10:0] len);
    logic [11:0] sum;
    sum = {1'b0, len} + 12'd3;
    return sum[11:2];
  endfunction

endpackage

`default_nettype wire

[rtl/core/fpwl_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module fpwl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/core/fpwl_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

module fpwl_engine (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire fpwl_pkg::fpwl_in_t  in_item_i,
  input  wire fpwl_pkg::fpwl_cfg_t cfg_i,
  input  wire logic               out_free_i,
  output fpwl_pkg::fpwl_sts_t      sts_o,
  output fpwl_pkg::fpwl_out_t      res_o
);

  import fpwl_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SCAN_GO, S_HEAD, S_TAIL, S_FIT, S_ZERO, S_ERASE,
    S_HDR, S_DATA, S_RDADDR, S_RDWAIT, S_RESP
  } state_e;

  state_e           state_q;
  fpwl_in_t         item_q;
  logic [PTR_W-1:0] ptr_q, head_q, tail_q, start_q, wp_q;
  logic [10:0]      br_q;
  logic [31:0]      asm_q;
  logic [1:0]       lane_q;
  fpwl_out_t        res_q;

  // memory port
  logic               ram_we, ram_re;
  logic [PAGE_AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;

  logic               in_fire;
  logic [PTR_W-1:0]   ptr_inc;
  logic               in_too_big, fit_over;
  logic [PTR_W-1:0]   rd_base;
  logic [CALC_W-1:0]  rd_sum;
  logic               rd_out;
  logic [31:0]        asm_new;
  logic               data_flush;
  logic [WORDS_W-1:0] item_words;

  fpwl_ram #(.WIDTH(32), .DEPTH(PAGE_WORDS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_fire    = in_valid_i && (state_q == S_IDLE);
  assign ptr_inc    = ptr_q + PTR_W'(1);
  assign item_words = fpwl_words(item_q.length);
  assign in_too_big = (CALC_W'(fpwl_words(in_item_i.length)) + CALC_W'(1))
                      > CALC_W'(PAGE_WORDS);
  assign fit_over   = (CALC_W'(tail_q) + CALC_W'(item_words) + CALC_W'(1))
                      > CALC_W'(PAGE_WORDS);

  // read address: skip header unless head sits in the last word
  assign rd_base = (head_q < PTR_LAST) ? (head_q + PTR_W'(1)) : head_q;
  assign rd_sum  = CALC_W'(rd_base) + CALC_W'(item_q.read_offset[10:2]);
  assign rd_out  = rd_sum >= CALC_W'(PAGE_WORDS);

  always_comb begin
    asm_new = asm_q;
    asm_new[{lane_q, 3'b000} +: 8] = item_q.data_byte;
  end
  assign data_flush = (lane_q == 2'd3) || (br_q == 11'd1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q[PAGE_AW-1:0];
    ram_wdata = WORD_ERASED;
    ram_re    = 1'b0;
    ram_raddr = ptr_inc[PAGE_AW-1:0];
    unique case (state_q)
      S_INIT, S_ERASE: begin
        ram_we = 1'b1;
      end
      S_ZERO: begin
        ram_we    = 1'b1;
        ram_wdata = WORD_ZERO;
      end
      S_HDR: begin
        ram_we    = 1'b1;
        ram_waddr = start_q[PAGE_AW-1:0];
        ram_wdata = cfg_i.header_word;
      end
      S_DATA: begin
        ram_we    = (br_q != 11'd0) && data_flush && (wp_q < PTR_PAGE);
        ram_waddr = wp_q[PAGE_AW-1:0];
        ram_wdata = asm_new;
      end
      S_SCAN_GO: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      S_HEAD: begin
        ram_re = (ram_rdata == WORD_ZERO) && (ptr_q != PTR_LAST);
      end
      S_TAIL: begin
        ram_re = (ram_rdata != WORD_ERASED) && (ptr_q != PTR_LAST);
      end
      S_RDADDR: begin
        ram_re    = !rd_out;
        ram_raddr = rd_sum[PAGE_AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      ptr_q   <= '0;
      wp_q    <= '0;
      br_q    <= '0;
      asm_q   <= '0;
      lane_q  <= '0;
    end else begin
      unique case (state_q)
        S_INIT: begin
          ptr_q <= ptr_inc;
          if (ptr_q == PTR_LAST) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            item_q          <= in_item_i;
            res_q.read_byte <= '0;
            res_q.status    <= ST_OK;
            unique case (in_item_i.opcode)
              OP_START_WRITE: begin
                if (in_too_big) begin
                  res_q.status <= ST_REJECT;
                  state_q      <= S_RESP;
                end else if (!cfg_i.wear_level_enable) begin
                  res_q.status <= ST_ERASED;
                  ptr_q        <= '0;
                  start_q      <= '0;
                  state_q      <= S_ERASE;
                end else begin
                  state_q <= S_SCAN_GO;
                end
              end
              OP_WRITE_DATA: state_q <= S_DATA;
              OP_READ_BYTE:  state_q <= S_SCAN_GO;
              default: begin
                res_q.status <= ST_REJECT;
                state_q      <= S_RESP;
              end
            endcase
          end
        end
        S_SCAN_GO: begin
          ptr_q   <= '0;
          state_q <= S_HEAD;
        end
        S_HEAD: begin
          if (ram_rdata == WORD_ZERO) begin
            if (ptr_q == PTR_LAST) begin
              head_q  <= PTR_PAGE;
              tail_q  <= PTR_PAGE;
              state_q <= (item_q.opcode == OP_READ_BYTE) ? S_RDADDR : S_FIT;
            end else begin
              ptr_q <= ptr_inc;
            end
          end else begin
            head_q  <= ptr_q;
            state_q <= (item_q.opcode == OP_READ_BYTE) ? S_RDADDR : S_TAIL;
          end
        end
        S_TAIL: begin
          if (ram_rdata != WORD_ERASED) begin
            if (ptr_q == PTR_LAST) begin
              tail_q  <= PTR_PAGE;
              state_q <= S_FIT;
            end else begin
              ptr_q <= ptr_inc;
            end
          end else begin
            tail_q  <= ptr_q;
            state_q <= S_FIT;
          end
        end
        S_FIT: begin
          if (fit_over) begin
            res_q.status <= ST_ERASED;
            ptr_q        <= '0;
            start_q      <= '0;
            state_q      <= S_ERASE;
          end else begin
            ptr_q   <= head_q;
            start_q <= tail_q;
            state_q <= (head_q == tail_q) ? S_HDR : S_ZERO;
          end
        end
        S_ZERO: begin
          ptr_q <= ptr_inc;
          if (ptr_inc == tail_q) begin
            state_q <= S_HDR;
          end
        end
        S_ERASE: begin
          ptr_q <= ptr_inc;
          if (ptr_q == PTR_LAST) begin
            state_q <= S_HDR;
          end
        end
        S_HDR: begin
          wp_q    <= start_q + PTR_W'(1);
          br_q    <= item_q.length;
          asm_q   <= '0;
          lane_q  <= '0;
          state_q <= S_RESP;
        end
        S_DATA: begin
          if (br_q == 11'd0) begin
            res_q.status <= ST_REJECT;
          end else begin
            br_q <= br_q - 11'd1;
            if (data_flush) begin
              wp_q   <= wp_q + PTR_W'(1);
              asm_q  <= '0;
              lane_q <= '0;
            end else begin
              asm_q  <= asm_new;
              lane_q <= lane_q + 2'd1;
            end
          end
          state_q <= S_RESP;
        end
        S_RDADDR: begin
          state_q <= rd_out ? S_RESP : S_RDWAIT;
        end
        S_RDWAIT: begin
          res_q.read_byte <= ram_rdata[{item_q.read_offset[1:0], 3'b000} +: 8];
          state_q         <= S_RESP;
        end
        S_RESP: begin
          if (out_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign sts_o.idle      = (state_q == S_IDLE);
  assign sts_o.res_valid = (state_q == S_RESP);
  assign res_o           = res_q;

endmodule

`default_nettype wire

[rtl/core/flash_page_record_wear_leveler_unit.sv]
// Single-page flash EEPROM emulation with wear leveling.
// Input requests (in_valid_i/in_ready_o, in_item_i) carry one of: start write
// (length), write data byte, read byte (offset). Every request gives exactly one
// result request on out_valid_o/out_ready_i (out_item_o: read_byte, status).
// Config writes (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): index 0 header
// word, 1 wear-level enable; other indexes are taken and ignored. Write only idle.
// One request at a time; in_ready_o is low while a request is being worked on.
// All page work goes through one page-word RAM port:
//   data byte: no scan; unused opcode, rejected start: no RAM access
//   read: scan for the head (first nonzero word), then a word read unless past the page end
//   start write, appending: head and tail scan plus zeroing sweep
//   start write, erasing: scan up to the tail plus a full-page erase sweep, tail = word the
//     scan stopped on; wear leveling off: full-page erase sweep with no scan
// After reset the page is erased by a clearing pass over every word; in_ready_o stays
// low until it ends. cfg_ready_o rises the cycle after reset is released.
// A finished result moves into the output register. While the receiver stalls,
// one more result can wait inside the engine; in_ready_o then stays low until
// the output register is drained, and rises the cycle after.
`timescale 1ns / 1ps
`default_nettype none

module flash_page_record_wear_leveler_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire fpwl_pkg::fpwl_in_t               in_item_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output fpwl_pkg::fpwl_out_t                   out_item_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [fpwl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [31:0]                      cfg_data_i
);

  import fpwl_pkg::*;

  fpwl_cfg_t cfg_q, cfg_d;
  logic      cfg_rdy_q;
  logic      out_valid_q, out_valid_d;
  fpwl_out_t out_item_q;
  fpwl_sts_t eng_sts;
  fpwl_out_t eng_res;
  logic      out_free;

  // Output slot free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  fpwl_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_item_i (in_item_i),
    .cfg_i     (cfg_q),
    .out_free_i(out_free),
    .sts_o     (eng_sts),
    .res_o     (eng_res)
  );

  // Config register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_rdy_q) begin
      unique case (cfg_index_i)
        CFG_HEADER_WORD: cfg_d.header_word       = cfg_data_i;
        CFG_WEAR_ENABLE: cfg_d.wear_level_enable = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (eng_sts.res_valid && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_word       <= HEADER_WORD_RST;
      cfg_q.wear_level_enable <= 1'b1;
      cfg_rdy_q               <= 1'b0;
      out_valid_q             <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      cfg_rdy_q   <= 1'b1;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_sts.res_valid && out_free) begin
      out_item_q <= eng_res;
    end
  end

  assign in_ready_o  = eng_sts.idle;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign cfg_ready_o = cfg_rdy_q;

endmodule

`default_nettype wire

[rtl/core/fpwl_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "flash_page_record_wear_leveler_unit_macros.svh"

module fpwl_chk (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire fpwl_pkg::fpwl_out_t out_item_o
);

  import fpwl_pkg::*;

  // stalled result holds
  `FPWL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))

  // one request in flight: ready drops after accept
  `FPWL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // erased and rejected results carry a zero data byte
  `FPWL_ASSERT_NOW(a_byte_zero, clk_i, rst_ni, out_valid_o && (out_item_o.status == ST_ERASED || out_item_o.status == ST_REJECT), out_item_o.read_byte == 8'd0)

  // a new result always follows a busy cycle
  `FPWL_ASSERT_NOW(a_result_after_work, clk_i, rst_ni, $rose(out_valid_o), $past(!in_ready_o))

endmodule

bind flash_page_record_wear_leveler_unit fpwl_chk u_fpwl_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);

`default_nettype wire

[test/tb_flash_page_record_wear_leveler_unit.sv]
`timescale 1ns / 1ps

module tb_flash_page_record_wear_leveler_unit;
  import fpwl_pkg::*;

  // Codes the package leaves out: the spare opcode and a register index the
  // block takes and ignores.
  localparam logic [1:0]           OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // A start write that has to erase costs a full scan plus a full sweep. The
  // watchdog is several times the slowest legal run.
  localparam int unsigned CYCLE_LIMIT   = 5_000_000;
  localparam int unsigned SETTLE_CYCLES = 1100;
  localparam int unsigned HOLD_CYCLES   = 400;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  fpwl_in_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  fpwl_out_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  flash_page_record_wear_leveler_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Page model: our own copy of the flash page and the open-record state.
  // ---------------------------------------------------------------------------
  logic [31:0] flash_img [PAGE_WORDS];
  logic [9:0]  wr_ptr;
  logic [11:0] bytes_left;
  logic [31:0] word_acc;
  logic [1:0]  lane;
  logic [31:0] hdr_word;
  logic        wear_en;

  // Replies the block owes us, oldest first.
  fpwl_out_t awaited_replies [$];

  int unsigned req_sent = 0;
  int unsigned replies_seen = 0;
  int unsigned err_cnt = 0;
  int unsigned erase_cnt = 0;
  int unsigned reject_cnt = 0;
  int unsigned read_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Stimulus knobs shared with the receiver (each has one writer).
  logic        calm = 1'b0;       // no idling on either side while set
  int unsigned hold_asked = 0;    // bumped by the sequencer to ask for a stall
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;

  function automatic void wipe_page();
    foreach (flash_img[i]) flash_img[i] = WORD_ERASED;
  endfunction

  // First word that is not zero; PAGE_WORDS if the page is all zero.
  function automatic int unsigned first_live_word();
    int unsigned a;
    a = 0;
    while (a < PAGE_WORDS && flash_img[a] == WORD_ZERO) a++;
    return a;
  endfunction

  function automatic logic [1:0] open_record(input logic [10:0] len);
    int unsigned nwords, head, tail, slot, a;
    logic [1:0]  verdict;
    nwords = (32'(len) + 3) >> 2;
    if (nwords + 1 > PAGE_WORDS) return ST_REJECT;   // too big, open write untouched
    slot = 0;
    verdict = ST_ERASED;
    if (wear_en) begin
      head = first_live_word();
      tail = head;
      while (tail < PAGE_WORDS && flash_img[tail] != WORD_ERASED) tail++;
      if (tail + nwords + 1 > PAGE_WORDS) begin
        wipe_page();
      end else begin
        // retire the old record in place, new one goes behind it
        for (a = head; a < tail; a++) flash_img[a] = WORD_ZERO;
        slot = tail;
        verdict = ST_OK;
      end
    end else begin
      wipe_page();
    end
    flash_img[slot] = hdr_word;
    wr_ptr = 10'(slot + 1);
    bytes_left = 12'(len);
    word_acc = '0;
    lane = '0;
    return verdict;
  endfunction

  function automatic logic [1:0] append_byte(input logic [7:0] b);
    if (bytes_left == 0) return ST_REJECT;
    word_acc[8*lane +: 8] = b;
    lane = lane + 2'd1;
    bytes_left = bytes_left - 12'd1;
    // word full or record done: program it, last word zero padded
    if (lane == 2'd0 || bytes_left == 0) begin
      if (wr_ptr < PAGE_WORDS) flash_img[wr_ptr] = word_acc;
      wr_ptr = wr_ptr + 10'd1;
      word_acc = '0;
      lane = '0;
    end
    return ST_OK;
  endfunction

  function automatic logic [7:0] fetch_byte(input logic [10:0] off);
    int unsigned base, addr;
    logic [31:0] w;
    base = first_live_word();
    if (base < PAGE_WORDS - 1) base++;   // header in the last word is not skipped
    addr = base + (off >> 2);
    if (addr >= PAGE_WORDS) return 8'h00;
    w = flash_img[addr];
    return w[8*off[1:0] +: 8];
  endfunction

  // Reply the block must give to one request; advances the page model.
  function automatic fpwl_out_t page_reply(input fpwl_in_t req);
    fpwl_out_t res;
    res = '0;
    case (req.opcode)
      OP_START_WRITE: res.status = open_record(req.length);
      OP_WRITE_DATA:  res.status = append_byte(req.data_byte);
      OP_READ_BYTE: begin
        res.read_byte = fetch_byte(req.read_offset);
        res.status = ST_OK;
      end
      default:        res.status = ST_REJECT;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Request side. Valid goes up at a clock edge and stays up until taken.
  // The model is stepped at acceptance, so prediction follows block order.
  // ---------------------------------------------------------------------------
  task automatic push_request(input fpwl_in_t req, input logic pinned = 1'b0,
                              input fpwl_out_t pinned_reply = '0);
    fpwl_out_t res;
    if (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 16);
    end
    in_valid <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (!in_ready);
    res = page_reply(req);
    if (pinned) res = pinned_reply;   // hand-written expectation for this row
    awaited_replies.push_back(res);
    req_sent++;
    if (res.status == ST_ERASED) erase_cnt++;
    if (res.status == ST_REJECT) reject_cnt++;
    if (req.opcode == OP_READ_BYTE) read_cnt++;
  endtask

  // Stop offering and wait until the block has handed back every reply.
  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_replies.size() != 0);
  endtask

  // Register writes only with the block idle. The spare index goes along each
  // time and must change nothing.
  task automatic set_config(input logic [31:0] hdr, input logic wear);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [31:0]          val [3];
    int unsigned          n;
    idx[0] = CFG_SPARE;
    val[0] = $urandom;
    idx[1] = CFG_HEADER_WORD;
    val[1] = hdr;
    idx[2] = CFG_WEAR_ENABLE;
    val[2] = {31'($urandom), wear};
    drain_replies();
    for (n = 0; n < 3; n++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[n];
      cfg_data <= val[n];
      do @(posedge clk); while (!cfg_ready);
      case (idx[n])
        CFG_HEADER_WORD: hdr_word = val[n];
        CFG_WEAR_ENABLE: wear_en = val[n][0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed records: a start write, its data bytes with reads
  // sprinkled in, then a few reads. The rest is noise: any opcode, stray
  // bytes, oversized lengths, abandoned or overrun records.
  task automatic run_record_traffic(input int unsigned budget);
    fpwl_in_t    req;
    int unsigned stop_at, len, nbytes, k, pick;
    logic        all_ones;
    stop_at = req_sent + budget;
    while (req_sent < stop_at) begin
      pick = $urandom_range(99);
      req = fpwl_in_t'($urandom);
      if (pick < 12) begin
        if (pick < 4) begin
          req.opcode = OP_START_WRITE;
          req.length = 11'($urandom_range(2045, 2047));
        end
        push_request(req);
      end else begin
        if (pick < 18) len = $urandom_range(2047);
        else if (pick < 30) len = $urandom_range(64);
        else len = $urandom_range(12);
        req.opcode = OP_START_WRITE;
        req.length = 11'(len);
        push_request(req);
        nbytes = (len > 48) ? $urandom_range(48) : len;
        if ($urandom_range(9) == 0) nbytes = $urandom_range(nbytes);
        else if ($urandom_range(9) == 0) nbytes += 2;
        // all-ones data yields words that look erased to the tail scan
        all_ones = ($urandom_range(5) == 0);
        for (k = 0; k < nbytes; k++) begin
          if ($urandom_range(9) == 0) begin
            req = fpwl_in_t'($urandom);
            req.opcode = OP_READ_BYTE;
            push_request(req);
          end
          req = fpwl_in_t'($urandom);
          req.opcode = OP_WRITE_DATA;
          if (all_ones) req.data_byte = 8'hFF;
          else if ($urandom_range(7) == 0) req.data_byte = 8'h00;
          push_request(req);
        end
        repeat ($urandom_range(1, 4)) begin
          req = fpwl_in_t'($urandom);
          req.opcode = OP_READ_BYTE;
          if ($urandom_range(3) != 0) req.read_offset = 11'($urandom_range(len + 4));
          push_request(req);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check at the handshake, then pick ready for the next cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    fpwl_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_item), '0);
      end else begin
        want = awaited_replies.pop_front();
        replies_seen++;
        if (out_item.read_byte !== want.read_byte)
          report_mismatch("read_byte", 32'(out_item.read_byte), 32'(want.read_byte));
        if (out_item.status !== want.status)
          report_mismatch("status", 32'(out_item.status), 32'(want.status));
      end
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_done != hold_asked) begin
      hold_done = hold_asked;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d replies outstanding", cycle_cnt,
             awaited_replies.size());
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Directed requests. Rows with pinned=1 carry the reply by hand; the rest
  // are checked against the page model.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    fpwl_in_t  req;
    logic      pinned;
    fpwl_out_t want;
  } probe_t;

  localparam int unsigned NPROBES = 26;
  localparam probe_t PROBES [NPROBES] = '{
    // fresh page is erased: reads give all ones, past the page end zero
    '{'{OP_READ_BYTE,   11'd0,    8'h00, 11'd0},    1'b1, '{8'hFF, ST_OK}},
    '{'{OP_READ_BYTE,   11'd0,    8'h00, 11'd2043}, 1'b1, '{8'hFF, ST_OK}},
    '{'{OP_READ_BYTE,   11'd0,    8'h00, 11'd2047}, 1'b1, '{8'h00, ST_OK}},
    // stray byte, spare opcode, oversized record
    '{'{OP_WRITE_DATA,  11'd0,    8'hFF, 11'd0},    1'b1, '{8'h00, ST_REJECT}},
    '{'{OP_UNUSED,      11'd2047, 8'hFF, 11'd2047}, 1'b1, '{8'h00, ST_REJECT}},
    '{'{OP_START_WRITE, 11'd2047, 8'h00, 11'd0},    1'b1, '{8'h00, ST_REJECT}},
    // header-only record, then a 5 byte one with a padded last word
    '{'{OP_START_WRITE, 11'd0,    8'h00, 11'd0},    1'b0, '0},
    '{'{OP_START_WRITE, 11'd5,    8'h00, 11'd0},    1'b0, '0},
    '{'{OP_WRITE_DATA,  11'd0,    8'h00, 11'd0},    1'b0, '0},
    '{'{OP_WRITE_DATA,  11'd0,    8'hFF, 11'd0},    1'b0, '0},
    '{'{OP_WRITE_DATA,  11'd0,    8'h80, 11'd0},    1'b0, '0},
    '{'{OP_WRITE_DATA,  11'd0,    8'h01, 11'd0},    1'b0, '0},
    '{'{OP_WRITE_DATA,  11'd0,    8'h7F, 11'd0},    1'b0, '0},
    '{'{OP_WRITE_DATA,  11'd0,    8'h33, 11'd0},    1'b1, '{8'h00, ST_REJECT}},
    '{'{OP_READ_BYTE,   11'd0,    8'h00, 11'd4},    1'b0, '0},
    // largest legal record does not fit behind the tail: page erase
    '{'{OP_START_WRITE, 11'd2044, 8'h00, 11'd0},    1'b0, '0},
    '{'{OP_WRITE_DATA,  11'd0,    8'hAA, 11'd0},    1'b0, '0},
    // oversized start leaves the open write alone
    '{'{OP_START_WRITE, 11'd2045, 8'h00, 11'd0},    1'b1, '{8'h00, ST_REJECT}},
    '{'{OP_WRITE_DATA,  11'd0,    8'h55, 11'd0},    1'b0, '0},
    // abandon the half word, then write an all-ones data word
    '{'{OP_START_WRITE, 11'd4,    8'h00, 11'd0},    1'b0, '0},
    '{'{OP_WRITE_DATA,  11'd0,    8'hFF, 11'd0},    1'b0, '0},
    '{'{OP_WRITE_DATA,  11'd0,    8'hFF, 11'd0},    1'b0, '0},
    '{'{OP_WRITE_DATA,  11'd0,    8'hFF, 11'd0},    1'b0, '0},
    '{'{OP_WRITE_DATA,  11'd0,    8'hFF, 11'd0},    1'b0, '0},
    // tail scan stops on that word
    '{'{OP_START_WRITE, 11'd0,    8'h00, 11'd0},    1'b0, '0},
    '{'{OP_READ_BYTE,   11'd0,    8'h00, 11'd0},    1'b0, '0}
  };

  initial begin : sequencer
    fpwl_in_t    req;
    int unsigned p, fill_start;
    logic [31:0] hdr;

    // model state after reset
    wipe_page();
    wr_ptr = '0;
    bytes_left = '0;
    word_acc = '0;
    lane = '0;
    hdr_word = HEADER_WORD_RST;
    wear_en = 1'b1;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings. The block clears the page first; handshakes absorb that.
    for (p = 0; p < NPROBES; p++)
      push_request(PROBES[p].req, PROBES[p].pinned, PROBES[p].want);

    // Walk the record to the last word with header-only records: each one
    // zeroes the previous. The first stretch runs with no idling at all.
    set_config(32'hFFFF_FFFE, 1'b1);
    calm = 1'b1;
    fill_start = req_sent;
    while (first_live_word() != PAGE_WORDS - 1) begin
      if (req_sent - fill_start == 150) calm = 1'b0;
      req = fpwl_in_t'($urandom);
      req.opcode = OP_START_WRITE;
      req.length = '0;
      push_request(req);
    end
    calm = 1'b0;
    // header sits in the last word: reads start on the header itself
    for (p = 0; p < 6; p++) begin
      req = fpwl_in_t'($urandom);
      req.opcode = OP_READ_BYTE;
      req.read_offset = 11'(p);
      push_request(req);
    end
    // no room left behind the tail: erase
    req = fpwl_in_t'($urandom);
    req.opcode = OP_START_WRITE;
    req.length = '0;
    push_request(req);

    // Wear leveling off: every start write erases.
    set_config(32'h0000_0001, 1'b0);
    run_record_traffic(110);

    // Back on with a random header. The receiver stalls for a long stretch
    // while requests keep coming, so the block backs up into its input.
    do hdr = $urandom; while (hdr == WORD_ZERO || hdr == WORD_ERASED);
    set_config(hdr, 1'b1);
    hold_asked++;
    run_record_traffic(120);
    // sender pause until everything is back
    drain_replies();
    run_record_traffic(100);

    do hdr = $urandom; while (hdr == WORD_ZERO || hdr == WORD_ERASED);
    set_config(hdr, 1'b1);
    run_record_traffic(60);

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d reads) over five register settings, %0d replies checked.",
             req_sent, read_cnt, replies_seen);
    $display("Saw %0d page erases, %0d rejects, %0d mismatches in %0d cycles.",
             erase_cnt, reject_cnt, err_cnt, cycle_cnt);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
